// ===== rtl/heater_thermostat_controller_macros.svh =====
// Assertion macros shared by the heater thermostat RTL.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef HEATER_THERMOSTAT_CONTROLLER_MACROS_SVH
`define HEATER_THERMOSTAT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define HTHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define HTHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hthc_pkg.sv =====
// Types, constants and conversion functions of the heater thermostat.
// No dependencies; imported by every module of the block.
package hthc_pkg;

	// Event kinds carried in the input tuser
	typedef enum logic [2:0] {
		REQ_ADC        = 3'd0,
		REQ_ZERO_CROSS = 3'd1,
		REQ_TICK       = 3'd2,
		REQ_FEEDBACK   = 3'd3,
		REQ_SET        = 3'd4,
		REQ_EMERGENCY  = 3'd5
	} req_type_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_OVERHEAT = 2'd1,
		ERR_SET_HIGH = 2'd2
	} err_code_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_NOISE_MARGIN     = 2'd0;
	localparam logic [1:0] CFG_HYSTERESIS_STEPS = 2'd1;
	localparam logic [1:0] CFG_OVERHEAT_LIMIT   = 2'd2;
	localparam logic [1:0] CFG_FEEDBACK_TIMEOUT = 2'd3;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 12;

	// Register reset values
	localparam logic [11:0] RST_NOISE_MARGIN     = 12'd0;
	localparam logic [3:0]  RST_HYSTERESIS_STEPS = 4'd2;
	localparam logic [11:0] RST_OVERHEAT_LIMIT   = 12'd3600;
	localparam logic [7:0]  RST_FEEDBACK_TIMEOUT = 8'd13;

	// Conversion constants
	localparam int STEP_COUNTS   = 42;
	localparam int CONV_MUL      = 169;
	localparam int CONV_OFFSET   = 8;
	localparam int SET_OFF_BELOW = 20;
	localparam int SET_MAX       = 90;
	// ceil(2^20 * 4 / 169): raw * this >> 20 gives raw*4/169 exactly for 12-bit raw
	localparam int RECIP_MUL     = 24819;
	localparam int RECIP_SHIFT   = 20;

	typedef struct packed {
		logic [11:0] noise_margin;
		logic [3:0]  hysteresis_steps;
		logic [11:0] overheat_limit;
		logic [7:0]  feedback_timeout;
	} cfg_t;

	typedef struct packed {
		req_type_t   req_type;
		logic [11:0] sample;
		logic [7:0]  set_celsius;
	} item_t;

	typedef struct packed {
		logic        heater_on;
		logic        feedback_present;
		err_code_t   error_code;
		logic        accepted;
		logic [6:0]  temperature_celsius;
		logic [11:0] target_level;
	} result_t;

	// Celsius set point (20..90) to raw target: (c - 8) * 169 / 4
	function automatic logic [11:0] celsius_to_raw(input logic [7:0] c);
		logic [14:0] prod;
		prod = (15'(c) - 15'(CONV_OFFSET)) * 15'(CONV_MUL);
		return prod[13:2];
	endfunction

	// Raw sample to whole degrees: raw * 4 / 169 + 8, by reciprocal multiply
	function automatic logic [6:0] raw_to_celsius(input logic [11:0] raw);
		logic [26:0] prod;
		prod = 27'(raw) * 27'(RECIP_MUL);
		return prod[RECIP_SHIFT +: 7] + 7'(CONV_OFFSET);
	endfunction

endpackage

// ===== rtl/heater_thermostat_controller.sv =====
// Heater thermostat top level: input register, event unit, output register.
// An event passes the input register and the event unit; its result waits in the output register.
// Throughput: one event per cycle unless m_tready stalls; state updates in one pass.
// The output register lets a new event enter while a result waits.
// Reset (arst_n low, asynchronous): state cleared, registers to reset values.
// Depends on hthc_pkg, hthc_cfg_regs and hthc_event_unit.
module heater_thermostat_controller
	import hthc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // sample[11:0], set_celsius[19:12], zero pad
	input  logic [2:0]            s_tuser,   // req_type[2:0]
	// Output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // heater_on[0], feedback_present[1],
	                                         // error_code[3:2], accepted[4],
	                                         // temperature_celsius[11:5], target_level[23:12]
	// Configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t out_q;
	logic    out_valid_q;
	logic    advance;

	// Stage 1 moves into the output register when that register is free or drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type    <= req_type_t'(s_tuser);
			item_s1.sample      <= s_tdata[11:0];
			item_s1.set_celsius <= s_tdata[19:12];
		end
	end

	hthc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hthc_event_unit u_event (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.target_level, out_q.temperature_celsius, out_q.accepted,
		out_q.error_code, out_q.feedback_present, out_q.heater_on};

endmodule

// ===== rtl/hthc_cfg_regs.sv =====
// Configuration register file of the heater thermostat.
// Depends on hthc_pkg for the register indexes, reset values and cfg_t.
module hthc_cfg_regs
	import hthc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Write-only registers, one per index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_margin     <= RST_NOISE_MARGIN;
			cfg_q.hysteresis_steps <= RST_HYSTERESIS_STEPS;
			cfg_q.overheat_limit   <= RST_OVERHEAT_LIMIT;
			cfg_q.feedback_timeout <= RST_FEEDBACK_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_NOISE_MARGIN:     cfg_q.noise_margin     <= cfg_wdata[11:0];
				CFG_HYSTERESIS_STEPS: cfg_q.hysteresis_steps <= cfg_wdata[3:0];
				CFG_OVERHEAT_LIMIT:   cfg_q.overheat_limit   <= cfg_wdata[11:0];
				CFG_FEEDBACK_TIMEOUT: cfg_q.feedback_timeout <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/hthc_event_unit.sv =====
// Thermostat state and per-event update logic; produces one result per event.
// Depends on hthc_pkg and heater_thermostat_controller_macros.svh.
`include "heater_thermostat_controller_macros.svh"

module hthc_event_unit
	import hthc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic [11:0] raw_q,    raw_d;
	logic [11:0] target_q, target_d;
	logic        heater_q, heater_d;
	logic        fb_flag_q, fb_flag_d;
	logic [7:0]  fb_age_q, fb_age_d;
	logic        hold_q,   hold_d;

	err_code_t   err;
	logic        acc;
	logic [9:0]  band;
	logic [13:0] thresh;
	logic [7:0]  age_inc;

	// Switch-on threshold: target - band - noise; bit 13 flags a negative value
	assign band    = 10'(cfg.hysteresis_steps) * 10'(STEP_COUNTS);
	assign thresh  = {2'b00, target_q} - {4'b0000, band} - {2'b00, cfg.noise_margin};
	assign age_inc = (fb_age_q != 8'hFF) ? fb_age_q + 8'd1 : fb_age_q;

	// Next state and status for the event at hand
	always_comb begin
		raw_d     = raw_q;
		target_d  = target_q;
		heater_d  = heater_q;
		fb_flag_d = fb_flag_q;
		fb_age_d  = fb_age_q;
		hold_d    = hold_q;
		err       = ERR_NONE;
		acc       = 1'b1;
		case (item.req_type)
			REQ_ADC: begin
				raw_d = item.sample;
				if (item.sample > cfg.overheat_limit) begin
					err = ERR_OVERHEAT;
				end
			end
			REQ_ZERO_CROSS: begin
				if (!hold_q) begin
					if (target_q == 12'd0 || raw_q >= target_q) begin
						heater_d = 1'b0;
					end else if (!thresh[13] && ({1'b0, raw_q} < thresh[12:0])) begin
						heater_d = 1'b1;
					end
				end
			end
			REQ_TICK: begin
				if (fb_flag_q) begin
					fb_age_d = age_inc;
					if (age_inc >= cfg.feedback_timeout) begin
						fb_flag_d = 1'b0;
					end
				end
			end
			REQ_FEEDBACK: begin
				fb_flag_d = 1'b1;
				fb_age_d  = 8'd0;
			end
			REQ_SET: begin
				if (item.set_celsius < 8'(SET_OFF_BELOW)) begin
					heater_d = 1'b0;
					target_d = 12'd0;
				end else if (item.set_celsius > 8'(SET_MAX)) begin
					err = ERR_SET_HIGH;
					acc = 1'b0;
				end else begin
					target_d = celsius_to_raw(item.set_celsius);
				end
			end
			REQ_EMERGENCY: begin
				hold_d   = 1'b1;
				heater_d = 1'b0;
				target_d = 12'd0;
			end
			default: ;
		endcase
	end

	// State registers advance once per processed event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q     <= 12'd0;
			target_q  <= 12'd0;
			heater_q  <= 1'b0;
			fb_flag_q <= 1'b0;
			fb_age_q  <= 8'd0;
			hold_q    <= 1'b0;
		end else if (step) begin
			raw_q     <= raw_d;
			target_q  <= target_d;
			heater_q  <= heater_d;
			fb_flag_q <= fb_flag_d;
			fb_age_q  <= fb_age_d;
			hold_q    <= hold_d;
		end
	end

	// Result reflects the state after the event
	always_comb begin
		result.heater_on           = heater_d;
		result.feedback_present    = fb_flag_d;
		result.error_code          = err;
		result.accepted            = acc;
		result.temperature_celsius = raw_to_celsius(raw_d);
		result.target_level        = target_d;
	end

	`HTHC_ASSERT_NOW(a_hold_keeps_off, hold_q, !heater_q, "heater on during manual hold")
	`HTHC_ASSERT_NEXT(a_emergency_clears, step && item.req_type == REQ_EMERGENCY,
		hold_q && !heater_q && target_q == 12'd0, "emergency did not force off")
	`HTHC_ASSERT_NOW(a_off_target_no_heat,
		step && item.req_type == REQ_ZERO_CROSS && target_q == 12'd0,
		!result.heater_on, "heater on with zero target")
	`HTHC_ASSERT_NEXT(a_pulse_sets_flag, step && item.req_type == REQ_FEEDBACK,
		fb_flag_q && fb_age_q == 8'd0, "feedback pulse lost")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for heater_thermostat_controller: directed and random events.
// Compares every output transaction with a built-in thermostat predictor.
// Depends on hthc_pkg and the heater_thermostat_controller RTL.
module testbench
	import hthc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Request codes that the block must treat as no-ops
	localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
	localparam int MAX_GAP = 18;
	localparam int HOLD_OFF_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata = '0;   // sample[11:0], set_celsius[19:12], zero pad
	logic [2:0]            s_tuser = '0;   // req_type[2:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;        // heater_on[0], feedback_present[1],
	                                       // error_code[3:2], accepted[4],
	                                       // temperature_celsius[11:5], target_level[23:12]
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Predictor copy of the registers and the controller state
	logic [11:0] cur_noise;
	logic [3:0]  cur_hyst;
	logic [11:0] cur_limit;
	logic [7:0]  cur_timeout;
	logic [11:0] th_raw;
	logic [11:0] th_target;
	logic        th_heat;
	logic        th_fb;
	logic [7:0]  th_age;
	logic        th_hold;

	result_t pending_results[$];
	bit      idle_on = 1'b1;
	int      hold_len = 0;
	int      events_sent = 0;
	int      results_checked = 0;
	int      settings_loaded = 0;
	int      mismatch_count = 0;

	heater_thermostat_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Thermostat behavior for one event: updates the state, returns the expected result
	function automatic result_t thermostat_next(input logic [2:0] kind, input logic [11:0] smp,
			input logic [7:0] cel);
		result_t   res;
		int        threshold;
		err_code_t err;
		logic      acc;
		err = ERR_NONE;
		acc = 1'b1;
		case (kind)
			REQ_ADC: begin
				th_raw = smp;
				if (smp > cur_limit)
					err = ERR_OVERHEAT;
			end
			REQ_ZERO_CROSS: begin
				if (!th_hold) begin
					threshold = int'(th_target) - int'(cur_hyst) * STEP_COUNTS - int'(cur_noise);
					if (th_target == 12'd0)
						th_heat = 1'b0;
					else if (th_raw >= th_target)
						th_heat = 1'b0;
					else if (threshold >= 0 && int'(th_raw) < threshold)
						th_heat = 1'b1;
				end
			end
			REQ_TICK: begin
				if (th_fb) begin
					if (th_age != 8'd255)
						th_age = th_age + 8'd1;
					if (th_age >= cur_timeout)
						th_fb = 1'b0;
				end
			end
			REQ_FEEDBACK: begin
				th_fb = 1'b1;
				th_age = 8'd0;
			end
			REQ_SET: begin
				if (cel < SET_OFF_BELOW) begin
					th_heat = 1'b0;
					th_target = 12'd0;
				end else if (cel > SET_MAX) begin
					err = ERR_SET_HIGH;
					acc = 1'b0;
				end else begin
					th_target = 12'((int'(cel) - CONV_OFFSET) * CONV_MUL / 4);
				end
			end
			REQ_EMERGENCY: begin
				th_hold = 1'b1;
				th_heat = 1'b0;
				th_target = 12'd0;
			end
			default: ;
		endcase
		res.heater_on = th_heat;
		res.feedback_present = th_fb;
		res.error_code = err;
		res.accepted = acc;
		res.temperature_celsius = 7'(int'(th_raw) * 4 / CONV_MUL + CONV_OFFSET);
		res.target_level = th_target;
		return res;
	endfunction

	// Offer one event, after a random gap while idle_on is set; called and returns at a rising edge
	task automatic send_event(input logic [2:0] kind, input logic [11:0] smp,
			input logic [7:0] cel);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'd0, cel, smp};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(thermostat_next(kind, smp, cel));
		events_sent++;
	endtask

	// Stop offering and wait until every expected result is out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges; block must be idle
	task automatic load_settings(input logic [11:0] noise, input logic [3:0] hyst,
			input logic [11:0] limit, input logic [7:0] tmo);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_NOISE_MARGIN;
		cfg_wdata <= noise;
		@(posedge clk);
		cfg_addr <= CFG_HYSTERESIS_STEPS;
		cfg_wdata <= 12'(hyst);
		@(posedge clk);
		cfg_addr <= CFG_OVERHEAT_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_addr <= CFG_FEEDBACK_TIMEOUT;
		cfg_wdata <= 12'(tmo);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_noise = noise;
		cur_hyst = hyst;
		cur_limit = limit;
		cur_timeout = tmo;
		settings_loaded++;
	endtask

	// One random event, weighted toward sequences that move the heater
	task automatic random_event();
		int          pick;
		int          span;
		int          level;
		logic [2:0]  kind;
		logic [11:0] smp;
		logic [7:0]  cel;
		pick = $urandom_range(0, 99);
		smp = 12'($urandom);
		cel = 8'($urandom);
		if (pick < 30) begin
			kind = REQ_ADC;
			// half the samples land around the switching points
			if ($urandom_range(0, 1) == 0) begin
				span = int'(cur_hyst) * STEP_COUNTS + int'(cur_noise) + 60;
				level = int'(th_target) + $urandom_range(0, 2 * span) - span;
				if (level < 0)
					level = 0;
				if (level > 4095)
					level = 4095;
				smp = 12'(level);
			end
		end else if (pick < 55)
			kind = REQ_ZERO_CROSS;
		else if (pick < 68)
			kind = REQ_TICK;
		else if (pick < 78)
			kind = REQ_FEEDBACK;
		else if (pick < 94) begin
			kind = REQ_SET;
			if ($urandom_range(0, 3) != 0)
				cel = 8'($urandom_range(SET_OFF_BELOW, SET_MAX));
		end else
			kind = $urandom_range(0, 1) ? REQ_UNUSED_LO : REQ_UNUSED_HI;
		send_event(kind, smp, cel);
	endtask

	// Random run with alternating stretches of idling and full rate
	task automatic random_run(input int count);
		for (int i = 0; i < count; i++) begin
			idle_on = ((i / 25) % 3) != 0;
			random_event();
		end
		idle_on = 1'b1;
	endtask

	task automatic apply_reset();
		arst_n = 1'b0;
		cur_noise = RST_NOISE_MARGIN;
		cur_hyst = RST_HYSTERESIS_STEPS;
		cur_limit = RST_OVERHEAT_LIMIT;
		cur_timeout = RST_FEEDBACK_TIMEOUT;
		th_raw = '0;
		th_target = '0;
		th_heat = 1'b0;
		th_fb = 1'b0;
		th_age = '0;
		th_hold = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Field extremes and every event kind but emergency under the reset settings
	task automatic test_reset_settings();
		send_event(REQ_ZERO_CROSS, 12'hFFF, 8'hFF);   // target 0 keeps heater off
		send_event(REQ_ADC, 12'd0, 8'd0);
		send_event(REQ_SET, 12'd0, 8'd19);            // low set point
		send_event(REQ_SET, 12'hFFF, 8'd20);
		send_event(REQ_ZERO_CROSS, 12'd0, 8'd0);      // cold: heater on
		send_event(REQ_SET, 12'd0, 8'd91);            // rejected
		send_event(REQ_SET, 12'd0, 8'd255);           // rejected
		send_event(REQ_SET, 12'd0, 8'd90);
		send_event(REQ_ADC, 12'd3601, 8'd0);          // overheat, still stored
		send_event(REQ_ADC, 12'd3600, 8'd0);
		send_event(REQ_ZERO_CROSS, 12'd0, 8'd0);      // at target: heater off
		send_event(REQ_ADC, 12'hFFF, 8'hFF);
		send_event(REQ_SET, 12'hFFF, 8'd0);
		send_event(REQ_TICK, 12'd0, 8'd0);            // tick with no feedback
		send_event(REQ_FEEDBACK, 12'hFFF, 8'hFF);
		send_event(REQ_TICK, 12'd0, 8'd0);
		send_event(REQ_UNUSED_LO, 12'hFFF, 8'hFF);
		send_event(REQ_UNUSED_HI, 12'hFFF, 8'hFF);
		random_run(110);
		settle();
	endtask

	// Widest band and margin: switch-on threshold goes negative
	task automatic test_high_extremes();
		load_settings(12'hFFF, 4'hF, 12'd0, 8'd255);
		send_event(REQ_SET, 12'd0, 8'd30);
		send_event(REQ_ADC, 12'd0, 8'd0);             // not above a zero limit
		send_event(REQ_ZERO_CROSS, 12'd0, 8'd0);      // negative threshold: not switched on
		send_event(REQ_ADC, 12'd1, 8'd0);             // overheat at limit 0
		random_run(110);
		settle();
	endtask

	// No band, no margin, highest overheat limit, timeout of 1
	task automatic test_low_extremes();
		load_settings(12'd0, 4'd0, 12'hFFF, 8'd1);
		send_event(REQ_ADC, 12'hFFF, 8'd0);           // never overheat
		random_run(110);
		settle();
	endtask

	// Feedback flag ageing at timeouts 0 and 255 with saturation of the age
	task automatic test_feedback_ageing();
		load_settings(12'd0, 4'd2, 12'd3600, 8'd0);
		send_event(REQ_FEEDBACK, 12'd0, 8'd0);
		send_event(REQ_TICK, 12'd0, 8'd0);
		send_event(REQ_TICK, 12'd0, 8'd0);
		settle();
		load_settings(12'd0, 4'd2, 12'd3600, 8'd255);
		idle_on = 1'b0;
		send_event(REQ_FEEDBACK, 12'd0, 8'd0);
		for (int i = 0; i < 258; i++)
			send_event(REQ_TICK, 12'($urandom), 8'($urandom));
		idle_on = 1'b1;
		settle();
	endtask

	// Random mid-range settings; the sink holds off so the block fills and stalls
	task automatic test_backpressure();
		load_settings(12'($urandom_range(0, 200)), 4'($urandom_range(0, 15)),
			12'($urandom_range(3000, 4095)), 8'($urandom_range(1, 30)));
		hold_len = HOLD_OFF_CYCLES;
		idle_on = 1'b0;
		for (int i = 0; i < 30; i++)
			random_event();
		random_run(80);
		settle();
	endtask

	// Emergency disable last: manual hold stays latched for the rest of the run
	task automatic test_manual_hold();
		load_settings(12'd10, 4'd1, 12'd3600, 8'd13);
		send_event(REQ_SET, 12'd0, 8'd60);
		send_event(REQ_ADC, 12'd0, 8'd0);
		send_event(REQ_ZERO_CROSS, 12'd0, 8'd0);      // heater on before the hold
		send_event(REQ_EMERGENCY, 12'hFFF, 8'hFF);
		send_event(REQ_SET, 12'd0, 8'd50);            // target still changes
		send_event(REQ_ZERO_CROSS, 12'd0, 8'd0);      // no switching under hold
		random_run(40);
		send_event(REQ_EMERGENCY, 12'd0, 8'd0);
		settle();
	endtask

	// Sink: random stall per result while idle_on is set, long hold-off on request
	initial begin : result_sink
		int stall;
		forever begin
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end else begin
				stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Check each output transaction against the oldest expectation
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.heater_on = m_tdata[0];
			got.feedback_present = m_tdata[1];
			got.error_code = err_code_t'(m_tdata[3:2]);
			got.accepted = m_tdata[4];
			got.temperature_celsius = m_tdata[11:5];
			got.target_level = m_tdata[23:12];
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: result with nothing expected: tdata %h", $realtime, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got !== want) begin
					if (mismatch_count < 10)
						$display("%0t: result %0d mismatch:", $realtime, results_checked,
							" expected heat %b fb %b err %0d acc %b temp %0d target %0d",
							want.heater_on, want.feedback_present, want.error_code,
							want.accepted, want.temperature_celsius, want.target_level,
							", got heat %b fb %b err %0d acc %b temp %0d target %0d",
							got.heater_on, got.feedback_present, got.error_code,
							got.accepted, got.temperature_celsius, got.target_level);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		apply_reset();
		test_reset_settings();
		test_high_extremes();
		test_low_extremes();
		test_feedback_ageing();
		test_backpressure();
		test_manual_hold();
		repeat (10) @(posedge clk);
		$display("Covered %0d events and %0d checked results over %0d register settings,",
			events_sent, results_checked, settings_loaded);
		$display("including negative thresholds, feedback ageing, back-pressure and manual hold.");
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
